// ----- rtl/core/mist_fan_mode_controller_macros.svh -----
// Assertion helpers for the mist controller core.
`ifndef MIST_FAN_MODE_CONTROLLER_MACROS_SVH
`define MIST_FAN_MODE_CONTROLLER_MACROS_SVH

// Same-cycle implication, sampled on the core clock, off during reset.
`define MFMC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the core clock, off during reset.
`define MFMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/mfmc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package mfmc_pkg;

  // Request kinds
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_KEY   = 2'd1,
    OP_TIMER = 2'd2,
    OP_WATER = 2'd3
  } op_e;

  // Session timer choices
  typedef enum logic [1:0] {
    TMR_NONE = 2'd0,
    TMR_60   = 2'd1,
    TMR_120  = 2'd2,
    TMR_BAD  = 2'd3
  } tmr_e;

  // Register indexes
  localparam logic [1:0] REG_TICKS_PER_MIN = 2'd0;
  localparam logic [1:0] REG_TOGGLE_PERIOD = 2'd1;
  localparam logic [1:0] REG_FAN_DELAY     = 2'd2;

  localparam int unsigned CntW  = 16;
  localparam int unsigned SessW = 23;

  localparam logic [CntW-1:0] TicksPerMinRst  = 16'd60000;
  localparam logic [CntW-1:0] TogglePeriodRst = 16'd10000;
  localparam logic [CntW-1:0] FanDelayRst     = 16'd10000;

  localparam logic [6:0] Mins60  = 7'd60;
  localparam logic [6:0] Mins120 = 7'd120;

endpackage
`default_nettype wire

// ----- rtl/core/mist_fan_mode_controller.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Mist controller core.
// Requests arrive on the s_axis channel: tuser carries the request kind
// (tick, key press, session timer select, water level), tdata carries the
// timer choice and the water-low flag. Every request yields exactly one
// status result on the m_axis channel: accepted flag, fan and mist drives,
// the two mode LEDs, misting status and the selected session timer.
// Three 16-bit registers (ticks per minute, toggle period, fan run-on) are
// written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the user must write them
// only while idle, as the block itself does not enforce it. A request is
// captured in an input register, evaluated in one pass of logic against the
// controller state, and the result lands in an output register; one request
// per cycle is sustained while the receiver takes results. The state is
// updated as each result is registered, so consecutive requests see each
// other's effects in order. When the receiver stalls the result holds, one
// more request waits in the input register, then s_axis_tready drops until
// the result is taken. Reset clears all state: misting off, continuous mode,
// no session timer, countdowns stopped, registers at their default values.
module mist_fan_mode_controller (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request channel
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [1:0] timer_choice, [2] water_low_in, rest 0
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] operation
  // result channel
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // [0] accepted, [1] fan_drive, [2] mist_drive,
                                          // [3] led_continuous, [4] led_intermittent,
                                          // [5] misting_active, [7:6] current_timer
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i
);
  import mfmc_pkg::*;

  // Configuration registers
  logic [CntW-1:0] tpm_q, tgl_period_q, fd_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpm_q        <= TicksPerMinRst;
      tgl_period_q <= TogglePeriodRst;
      fd_ticks_q   <= FanDelayRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TICKS_PER_MIN: tpm_q        <= cfg_wdata_i;
        REG_TOGGLE_PERIOD: tgl_period_q <= cfg_wdata_i;
        REG_FAN_DELAY:     fd_ticks_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input register
  logic       in_valid_q;
  op_e        op_q;
  logic [1:0] choice_q;
  logic       wl_q;
  logic       advance;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q     <= op_e'(s_axis_tuser);
      choice_q <= s_axis_tdata[1:0];
      wl_q     <= s_axis_tdata[2];
    end
  end

  // Controller state
  logic             misting_q, misting_d;
  logic             intm_q, intm_d;
  logic [1:0]       tsel_q, tsel_d;
  logic             water_low_q, water_low_d;
  logic             fan_q, fan_d;
  logic             mist_q, mist_d;
  logic             phase_q, phase_d;
  logic [CntW-1:0]  tg_cnt_q, tg_cnt_d;
  logic             tg_run_q, tg_run_d;
  logic [SessW-1:0] ss_cnt_q, ss_cnt_d;
  logic             ss_run_q, ss_run_d;
  logic [CntW-1:0]  fd_cnt_q, fd_cnt_d;
  logic             fd_run_q, fd_run_d;
  logic             acc;

  // Session length: minutes times ticks per minute, kept to 23 bits
  logic [6:0]       mins;
  logic [22:0]      sess_prod;
  assign mins      = (choice_q == TMR_60) ? Mins60 : Mins120;
  assign sess_prod = 23'(mins * tpm_q);

  // Request evaluation
  always_comb begin
    misting_d   = misting_q;
    intm_d      = intm_q;
    tsel_d      = tsel_q;
    water_low_d = water_low_q;
    fan_d       = fan_q;
    mist_d      = mist_q;
    phase_d     = phase_q;
    tg_cnt_d    = tg_cnt_q;
    tg_run_d    = tg_run_q;
    ss_cnt_d    = ss_cnt_q;
    ss_run_d    = ss_run_q;
    fd_cnt_d    = fd_cnt_q;
    fd_run_d    = fd_run_q;
    acc         = 1'b0;
    case (op_q)
      OP_TICK: begin
        // fan run-on first
        if (fd_run_q) begin
          if (fd_cnt_q <= 16'd1) begin
            fd_run_d = 1'b0;
            fan_d    = 1'b0;
            acc      = 1'b1;
          end else begin
            fd_cnt_d = fd_cnt_q - 16'd1;
          end
        end
        // intermittent toggle, reloads itself
        if (tg_run_q) begin
          if (tg_cnt_q <= 16'd1) begin
            tg_cnt_d = tgl_period_q;
            fan_d    = !phase_q;
            mist_d   = !phase_q;
            phase_d  = !phase_q;
            acc      = 1'b1;
          end else begin
            tg_cnt_d = tg_cnt_q - 16'd1;
          end
        end
        // session timer, one-shot; expiry halts misting
        if (ss_run_q) begin
          if (ss_cnt_q <= 23'd1) begin
            ss_run_d = 1'b0;
            acc      = 1'b1;
            if (misting_q) begin
              tg_run_d  = 1'b0;
              mist_d    = 1'b0;
              fd_cnt_d  = fd_ticks_q;
              fd_run_d  = 1'b1;
              misting_d = 1'b0;
            end
          end else begin
            ss_cnt_d = ss_cnt_q - 23'd1;
          end
        end
      end
      OP_KEY: begin
        if (!misting_q) begin
          if (!water_low_q) begin
            fd_run_d  = 1'b0;
            tg_run_d  = 1'b0;
            intm_d    = 1'b0;
            fan_d     = 1'b1;
            mist_d    = 1'b1;
            misting_d = 1'b1;
            acc       = 1'b1;
          end
        end else if (!intm_q) begin
          tg_cnt_d = tgl_period_q;
          tg_run_d = 1'b1;
          intm_d   = 1'b1;
          acc      = 1'b1;
        end else begin
          tg_run_d  = 1'b0;
          mist_d    = 1'b0;
          fd_cnt_d  = fd_ticks_q;
          fd_run_d  = 1'b1;
          misting_d = 1'b0;
          acc       = 1'b1;
        end
      end
      OP_TIMER: begin
        if (misting_q && choice_q != tsel_q && choice_q != TMR_BAD) begin
          if (choice_q == TMR_NONE) begin
            ss_run_d = 1'b0;
          end else begin
            ss_cnt_d = sess_prod;
            ss_run_d = 1'b1;
          end
          tsel_d = choice_q;
          acc    = 1'b1;
        end
      end
      OP_WATER: begin
        acc         = (wl_q != water_low_q);
        water_low_d = wl_q;
      end
      default: ;
    endcase
  end

  logic fire;
  assign fire = in_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      misting_q   <= 1'b0;
      intm_q      <= 1'b0;
      tsel_q      <= TMR_NONE;
      water_low_q <= 1'b0;
      fan_q       <= 1'b0;
      mist_q      <= 1'b0;
      phase_q     <= 1'b0;
      tg_cnt_q    <= '0;
      tg_run_q    <= 1'b0;
      ss_cnt_q    <= '0;
      ss_run_q    <= 1'b0;
      fd_cnt_q    <= '0;
      fd_run_q    <= 1'b0;
    end else if (fire) begin
      misting_q   <= misting_d;
      intm_q      <= intm_d;
      tsel_q      <= tsel_d;
      water_low_q <= water_low_d;
      fan_q       <= fan_d;
      mist_q      <= mist_d;
      phase_q     <= phase_d;
      tg_cnt_q    <= tg_cnt_d;
      tg_run_q    <= tg_run_d;
      ss_cnt_q    <= ss_cnt_d;
      ss_run_q    <= ss_run_d;
      fd_cnt_q    <= fd_cnt_d;
      fd_run_q    <= fd_run_d;
    end
  end

  // Result register
  logic [7:0] res_d;
  assign res_d = {tsel_d, misting_d, misting_d & intm_d, misting_d & !intm_d,
                  mist_d, fan_d, acc};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      m_axis_tdata <= res_d;
    end
  end

  // Checks
  `include "mist_fan_mode_controller_macros.svh"

  `MFMC_ASSERT_NOW(a_toggle_needs_misting, !misting_q, !tg_run_q, "toggle running while off")
  `MFMC_ASSERT_NOW(a_runon_only_when_off, misting_q, !fd_run_q, "fan run-on while misting")
  `MFMC_ASSERT_NOW(a_session_has_choice, ss_run_q, tsel_q != TMR_NONE, "session without timer")
  `MFMC_ASSERT_NEXT(a_input_held, in_valid_q && !advance, in_valid_q && $stable(op_q),
                    "waiting request lost")

endmodule
`default_nettype wire

// ----- tb/sv/mist_fan_mode_controller_tb.sv -----
`timescale 1ns / 1ps
module mist_fan_mode_controller_tb;
  import mfmc_pkg::*;

  localparam int unsigned CycleLimit = 200000;

  // Result fields, packed in the same order as m_axis_tdata
  typedef struct packed {
    logic [1:0] timer;
    logic       misting;
    logic       led_int;
    logic       led_cont;
    logic       mist;
    logic       fan;
    logic       accepted;
  } status_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_wdata_i = '0;

  // Idling controls
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned rx_hold_left = 0;

  int unsigned n_err = 0;
  int unsigned n_results = 0;
  int unsigned cycles = 0;

  status_t pending_status[$];

  // Controller timing as the block holds it
  logic [15:0] cfg_tpm = TicksPerMinRst;
  logic [15:0] cfg_toggle = TogglePeriodRst;
  logic [15:0] cfg_fan = FanDelayRst;

  // Controller state
  logic        misting = 1'b0;
  logic        intermittent = 1'b0;
  tmr_e        timer_sel = TMR_NONE;
  logic        water_is_low = 1'b0;
  logic        fan_on = 1'b0;
  logic        mist_on = 1'b0;
  logic        phase_on = 1'b0;
  logic [15:0] tgl_cnt = '0;
  logic        tgl_run = 1'b0;
  logic [22:0] sess_cnt = '0;
  logic        sess_run = 1'b0;
  logic [15:0] fan_cnt = '0;
  logic        fan_run = 1'b0;

  mist_fan_mode_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),  // [1:0] timer_choice, [2] water_low_in
    .s_axis_tuser  (s_axis_tuser),  // [1:0] operation
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),  // [0] accepted .. [5] misting_active, [7:6] current_timer
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // Misting stops: mist off, toggle halted, fan run-on armed
  function automatic void stop_misting();
    if (misting) begin
      tgl_run = 1'b0;
      mist_on = 1'b0;
      fan_cnt = cfg_fan;
      fan_run = 1'b1;
      misting = 1'b0;
    end
  endfunction

  // Apply one request to the controller state, return the status it yields
  function automatic status_t advance_controller(op_e op, tmr_e choice, logic wl);
    status_t res;
    logic acc;
    logic [31:0] span;
    acc = 1'b0;
    case (op)
      OP_TICK: begin
        // fan run-on, then toggle, then session
        if (fan_run) begin
          if (fan_cnt <= 1) begin
            fan_run = 1'b0;
            fan_on = 1'b0;
            acc = 1'b1;
          end else begin
            fan_cnt = fan_cnt - 1'b1;
          end
        end
        if (tgl_run) begin
          if (tgl_cnt <= 1) begin
            tgl_cnt = cfg_toggle;
            fan_on = !phase_on;
            mist_on = !phase_on;
            phase_on = !phase_on;
            acc = 1'b1;
          end else begin
            tgl_cnt = tgl_cnt - 1'b1;
          end
        end
        if (sess_run) begin
          if (sess_cnt <= 1) begin
            sess_run = 1'b0;
            stop_misting();
            acc = 1'b1;
          end else begin
            sess_cnt = sess_cnt - 1'b1;
          end
        end
      end
      OP_KEY: begin
        if (!misting) begin
          if (!water_is_low) begin
            fan_run = 1'b0;
            tgl_run = 1'b0;
            intermittent = 1'b0;
            fan_on = 1'b1;
            mist_on = 1'b1;
            misting = 1'b1;
            acc = 1'b1;
          end
        end else if (!intermittent) begin
          tgl_cnt = cfg_toggle;
          tgl_run = 1'b1;
          intermittent = 1'b1;
          acc = 1'b1;
        end else begin
          stop_misting();
          acc = 1'b1;
        end
      end
      OP_TIMER: begin
        if (misting && choice != timer_sel && choice != TMR_BAD) begin
          if (choice == TMR_NONE) begin
            sess_run = 1'b0;
          end else begin
            span = ((choice == TMR_60) ? Mins60 : Mins120) * cfg_tpm;
            sess_cnt = span[22:0];
            sess_run = 1'b1;
          end
          timer_sel = choice;
          acc = 1'b1;
        end
      end
      default: begin
        acc = (wl != water_is_low);
        water_is_low = wl;
      end
    endcase
    res.accepted = acc;
    res.fan = fan_on;
    res.mist = mist_on;
    res.led_cont = misting && !intermittent;
    res.led_int = misting && intermittent;
    res.misting = misting;
    res.timer = timer_sel;
    return res;
  endfunction

  // One line per mismatch, each one counted
  task automatic flag_error(string what, int got, int want);
    $display("[%0t] result %0d: %s got %0d, expected %0d", $realtime, n_results, what,
             got, want);
    n_err++;
  endtask

  // Score results against the oldest expectation, then log new requests
  always @(posedge clk_i) begin : score
    status_t got;
    status_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = status_t'(m_axis_tdata);
        if (pending_status.size() == 0) begin
          flag_error("unexpected result, tdata", m_axis_tdata, 0);
        end else begin
          want = pending_status.pop_front();
          if (got.accepted !== want.accepted) flag_error("accepted", got.accepted, want.accepted);
          if (got.fan !== want.fan) flag_error("fan_drive", got.fan, want.fan);
          if (got.mist !== want.mist) flag_error("mist_drive", got.mist, want.mist);
          if (got.led_cont !== want.led_cont)
            flag_error("led_continuous", got.led_cont, want.led_cont);
          if (got.led_int !== want.led_int)
            flag_error("led_intermittent", got.led_int, want.led_int);
          if (got.misting !== want.misting)
            flag_error("misting_active", got.misting, want.misting);
          if (got.timer !== want.timer) flag_error("current_timer", got.timer, want.timer);
        end
        n_results++;
      end
      if (s_axis_tvalid && s_axis_tready)
        pending_status.push_back(advance_controller(op_e'(s_axis_tuser),
                                                    tmr_e'(s_axis_tdata[1:0]),
                                                    s_axis_tdata[2]));
    end
  end

  // Receiver: long hold-off when asked, otherwise random stalls
  always @(negedge clk_i) begin
    if (rx_hold_left > 0) begin
      m_axis_tready = 1'b0;
      rx_hold_left--;
    end else begin
      m_axis_tready = ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offer one request, with random idle cycles ahead of it
  task automatic send_request(op_e op, tmr_e choice, logic wl);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = op;
    s_axis_tdata = {5'b0, wl, choice};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_noise();
    send_request(op_e'($urandom_range(0, 3)), tmr_e'($urandom_range(0, 3)),
                 $urandom_range(0, 1) != 0);
  endtask

  // Stop offering and wait until every expected result is in
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_status.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_TICKS_PER_MIN: cfg_tpm = value;
      REG_TOGGLE_PERIOD: cfg_toggle = value;
      REG_FAN_DELAY:     cfg_fan = value;
      default: ;
    endcase
  endtask

  task automatic load_timing(logic [15:0] tpm, logic [15:0] tgl, logic [15:0] fan);
    wait_idle();
    write_reg(REG_TICKS_PER_MIN, tpm);
    write_reg(REG_TOGGLE_PERIOD, tgl);
    write_reg(REG_FAN_DELAY, fan);
  endtask

  // Mostly whole sessions: refill, start, maybe intermittent, pick a timer,
  // then a run of 1 to 140 ticks in which timers may expire; the rest is noise
  task automatic run_mist_sessions(int unsigned n_items);
    int unsigned sent;
    int unsigned n_ticks;
    int unsigned pick;
    tmr_e tmr;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 7) begin
        send_request(OP_WATER, tmr_e'($urandom_range(0, 3)), 1'b0);
        send_request(OP_KEY, tmr_e'($urandom_range(0, 3)), $urandom_range(0, 1) != 0);
        sent += 2;
        if ($urandom_range(0, 1) != 0) begin
          send_request(OP_KEY, tmr_e'($urandom_range(0, 3)), $urandom_range(0, 1) != 0);
          sent++;
        end
        pick = $urandom_range(0, 9);
        tmr = (pick < 4) ? TMR_60 : (pick < 8) ? TMR_120 : (pick == 8) ? TMR_NONE : TMR_BAD;
        send_request(OP_TIMER, tmr, $urandom_range(0, 1) != 0);
        sent++;
        n_ticks = $urandom_range(1, 140);
        repeat (n_ticks) begin
          if ($urandom_range(0, 15) == 0)
            send_noise();
          else
            send_request(OP_TICK, tmr_e'($urandom_range(0, 3)), $urandom_range(0, 1) != 0);
        end
        sent += n_ticks;
      end else begin
        repeat (4) send_noise();
        sent += 4;
      end
    end
  endtask

  // Each mode, refusals, toggle and run-on expiry, timer choices
  task automatic test_directed_modes();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    load_timing(16'd1, 16'd2, 16'd2);
    send_request(OP_TICK, TMR_NONE, 1'b0);    // nothing running
    send_request(OP_TIMER, TMR_60, 1'b0);     // refused while off
    send_request(OP_WATER, TMR_NONE, 1'b1);   // tank low
    send_request(OP_WATER, TMR_BAD, 1'b1);    // unchanged level
    send_request(OP_KEY, TMR_NONE, 1'b0);     // start refused on low water
    send_request(OP_WATER, TMR_NONE, 1'b0);
    send_request(OP_KEY, TMR_NONE, 1'b0);     // continuous
    send_request(OP_TIMER, TMR_60, 1'b0);
    send_request(OP_TIMER, TMR_60, 1'b1);     // same choice refused
    send_request(OP_TIMER, TMR_BAD, 1'b0);    // invalid choice
    send_request(OP_TIMER, TMR_120, 1'b0);
    send_request(OP_TIMER, TMR_NONE, 1'b0);   // session stopped
    send_request(OP_KEY, TMR_NONE, 1'b0);     // intermittent
    repeat (4) send_request(OP_TICK, TMR_BAD, 1'b1);
    send_request(OP_WATER, TMR_NONE, 1'b1);   // low water, misting carries on
    send_request(OP_KEY, TMR_NONE, 1'b0);     // stop, fan run-on
    repeat (2) send_request(OP_TICK, TMR_NONE, 1'b0);
    send_request(OP_WATER, TMR_NONE, 1'b0);
    send_request(OP_KEY, TMR_NONE, 1'b0);
    send_request(OP_KEY, TMR_NONE, 1'b0);
    send_request(OP_KEY, TMR_NONE, 1'b0);
    send_request(OP_KEY, TMR_NONE, 1'b0);     // restart cancels run-on
  endtask

  // Receiver holds off while requests keep coming, then a full drain and more sessions
  task automatic test_output_stall();
    load_timing(16'd1, 16'd3, 16'd4);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    @(posedge clk_i);
    rx_hold_left = 300;
    repeat (40) send_noise();
    wait_idle();
    run_mist_sessions(40);
  endtask

  task automatic test_shortest_countdowns();
    load_timing(16'd1, 16'd1, 16'd1);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    run_mist_sessions(280);
  endtask

  task automatic test_sender_gaps();
    load_timing(16'd1, 16'($urandom_range(2, 6)), 16'($urandom_range(1, 8)));
    tx_idle_pct = 57;
    rx_stall_pct = 0;
    run_mist_sessions(280);
  endtask

  task automatic test_receiver_stalls();
    load_timing(16'd2, 16'($urandom_range(1, 9)), 16'($urandom_range(1, 12)));
    tx_idle_pct = 0;
    rx_stall_pct = 57;
    run_mist_sessions(280);
  endtask

  task automatic test_both_idle();
    load_timing(16'd1, 16'd3, 16'd5);
    tx_idle_pct = 25;
    rx_stall_pct = 25;
    run_mist_sessions(280);
  endtask

  // Large register values (toggle and run-on at maximum): long session loads, nothing expires
  task automatic test_longest_countdowns();
    load_timing(16'd60000, 16'd65535, 16'd65535);
    tx_idle_pct = 25;
    rx_stall_pct = 25;
    send_request(OP_WATER, TMR_NONE, 1'b0);
    send_request(OP_KEY, TMR_NONE, 1'b0);
    send_request(OP_TIMER, TMR_120, 1'b0);
    send_request(OP_TIMER, TMR_60, 1'b0);
    send_request(OP_KEY, TMR_NONE, 1'b0);
    repeat (50) send_noise();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed_modes();
    test_shortest_countdowns();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_longest_countdowns();
    test_output_stall();
    wait_idle();
    repeat (10) @(posedge clk_i);
    if (n_err == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
